[rtl/signed_int_to_decimal_ascii_unit_macros.svh]
// Assertion macros shared by the decimal text converter
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SIDASC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sidasc: same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define SIDASC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sidasc: next-cycle check failed");

`endif

[rtl/sidasc_pkg.sv]
// Types, constants and tables shared by the decimal text converter
package sidasc_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int POS_W      = 4;   // digit position 0..9
  localparam int CMP_W      = 34;  // holds 9 * 10^9
  localparam int MAX_DIGITS = 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  // classified item passed from front to back
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [POS_W-1:0]   top_pos;  // position of the leading digit
  } item_t;

  // power of ten for a digit position
  function automatic logic [CMP_W-1:0] pow10(input logic [POS_W-1:0] p);
    logic [CMP_W-1:0] r;
    case (p)
      4'd0:    r = 34'd1;
      4'd1:    r = 34'd10;
      4'd2:    r = 34'd100;
      4'd3:    r = 34'd1000;
      4'd4:    r = 34'd10000;
      4'd5:    r = 34'd100000;
      4'd6:    r = 34'd1000000;
      4'd7:    r = 34'd10000000;
      4'd8:    r = 34'd100000000;
      4'd9:    r = 34'd1000000000;
      default: r = 34'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/sidasc_front.sv]
// Front end: takes the signed value, forms sign, magnitude and leading digit position
module sidasc_front (
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,   // [31:0] value
  output logic                      item_valid,
  input  logic                      item_ready,
  output sidasc_pkg::item_t         item
);

  logic                               neg;
  logic [sidasc_pkg::VALUE_W-1:0]     mag;
  logic [sidasc_pkg::POS_W-1:0]       top_pos;

  // magnitude in unsigned arithmetic, so the most negative value is exact
  always_comb begin
    neg = s_tdata[sidasc_pkg::VALUE_W-1];
    mag = neg ? (~s_tdata + 32'd1) : s_tdata;
  end

  // leading digit position: number of powers of ten from 10^1 up not above the magnitude
  always_comb begin
    top_pos = '0;
    for (int p = 1; p < sidasc_pkg::MAX_DIGITS; p++) begin
      if ({2'b00, mag} >= sidasc_pkg::pow10(sidasc_pkg::POS_W'(p)))
        top_pos = top_pos + 4'd1;
    end
  end

  assign item.neg     = neg;
  assign item.mag     = mag;
  assign item.top_pos = top_pos;

  assign item_valid = s_tvalid;
  assign s_tready   = item_ready;

endmodule

[rtl/sidasc_queue.sv]
// Short queue of classified items between front and back
module sidasc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  sidasc_pkg::item_t push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output sidasc_pkg::item_t pop_item
);

  localparam int DEPTH = sidasc_pkg::QUEUE_DEPTH;

  sidasc_pkg::item_t                entries [DEPTH];
  logic [sidasc_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [sidasc_pkg::QCNT_W-1:0]    count;
  logic                             do_push, do_pop;

  assign push_ready = (count != sidasc_pkg::QCNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push)
      entries[wr_ptr] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == sidasc_pkg::QPTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == sidasc_pkg::QPTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !do_push)
        count <= count - 1'b1;
    end
  end

endmodule

[rtl/sidasc_back.sv]
// Back end: emits the sign, then one decimal digit per cycle while the output is not stalled, leading digit first
module sidasc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  sidasc_pkg::item_t                 item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sidasc_pkg::CHAR_W-1:0]     out_char,
  output logic                              out_last
);

  logic                               busy, busy_next;
  logic                               sign_pend, sign_pend_next;
  logic [sidasc_pkg::POS_W-1:0]       pos, pos_next;
  logic [sidasc_pkg::VALUE_W-1:0]     rem, rem_next;
  logic [sidasc_pkg::CHAR_W-1:0]      char_next;
  logic                               last_next;

  logic                               slot_free, go;
  logic                               src_sign;
  logic [sidasc_pkg::POS_W-1:0]       src_pos;
  logic [sidasc_pkg::VALUE_W-1:0]     src_mag;
  logic [sidasc_pkg::CMP_W-1:0]       unit, take;
  logic [3:0]                         digit;

  // output register is free when empty or being drained
  assign slot_free  = !out_valid || out_ready;
  assign go         = slot_free && (busy || item_valid);
  assign item_ready = slot_free && !busy;

  // work on the held item, or straight on the queue head when idle
  always_comb begin
    src_sign = busy ? sign_pend : item.neg;
    src_pos  = busy ? pos       : item.top_pos;
    src_mag  = busy ? rem       : item.mag;
  end

  // digit at this position: largest k with k * 10^pos not above the remainder
  always_comb begin
    unit  = sidasc_pkg::pow10(src_pos);
    digit = 4'd0;
    take  = '0;
    for (int k = 1; k < 10; k++) begin
      if ({2'b00, src_mag} >= unit * sidasc_pkg::CMP_W'(k)) begin
        digit = 4'(k);
        take  = unit * sidasc_pkg::CMP_W'(k);
      end
    end
  end

  // next character and progress
  always_comb begin
    busy_next      = busy;
    sign_pend_next = sign_pend;
    pos_next       = pos;
    rem_next       = rem;
    char_next      = out_char;
    last_next      = out_last;
    if (go) begin
      if (src_sign) begin
        char_next      = sidasc_pkg::CHAR_MINUS;
        last_next      = 1'b0;
        sign_pend_next = 1'b0;
        busy_next      = 1'b1;
        pos_next       = src_pos;
        rem_next       = src_mag;
      end else begin
        char_next      = sidasc_pkg::CHAR_ZERO + {2'b00, digit};
        last_next      = (src_pos == '0);
        sign_pend_next = 1'b0;
        busy_next      = (src_pos != '0);
        pos_next       = src_pos - 1'b1;
        rem_next       = src_mag - take[sidasc_pkg::VALUE_W-1:0];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      sign_pend <= sign_pend_next;
      if (slot_free)
        out_valid <= go;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    rem      <= rem_next;
    out_char <= char_next;
    out_last <= last_next;
  end

endmodule

[rtl/signed_int_to_decimal_ascii_unit.sv]
// Signed 32-bit integer to decimal ASCII text converter, top level
// Each transaction on the slave side carries one signed value; the master side
// returns its decimal text one character per transaction, leading minus sign
// (for negative values) first, then digits from the most significant, with
// tlast on the final character. Zero gives a single '0' and the most negative
// value gives "-2147483648". An item gives 1 to 11 characters; the back end
// produces one digit per cycle, while m_tready does not hold it, into a
// single-character output register; a two-entry queue lets new values be taken
// while a conversion is in progress.
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module signed_int_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
  output logic        m_tlast    // last_char
);

  sidasc_pkg::item_t                  front_item, queue_item;
  logic                               front_valid, front_ready;
  logic                               queue_valid, queue_ready;
  logic [sidasc_pkg::CHAR_W-1:0]      out_char;
  logic                               out_is_minus, out_is_digit;

  // classify incoming values
  sidasc_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  // decouple front and back
  sidasc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  // digit generation
  sidasc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (out_char),
    .out_last   (m_tlast)
  );

  assign m_tdata = {2'b00, out_char};

  // character classes for the checks below
  assign out_is_minus = (out_char == sidasc_pkg::CHAR_MINUS);
  assign out_is_digit = (out_char >= sidasc_pkg::CHAR_ZERO) &&
                        (out_char <= sidasc_pkg::CHAR_NINE);

  // character is always a minus sign or a decimal digit
  `SIDASC_ASSERT_IMPL(a_char_legal, m_tvalid, out_is_minus || out_is_digit)
  // a minus sign never ends a run
  `SIDASC_ASSERT_IMPL(a_minus_not_last, m_tvalid && out_is_minus, !m_tlast)
  // a minus sign is followed by a digit, never by another sign
  `SIDASC_ASSERT_NEXT(a_digit_after_minus, m_tvalid && m_tready && out_is_minus, !(m_tvalid && out_is_minus))

endmodule

[tb/sv/decimal_text_monitor.sv]
// Channel monitor for the decimal text converter: predicts each character and compares results
module decimal_text_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
  input  logic        m_tlast,   // last_char
  output int          fail_count,
  output int          chars_pending
);

  typedef struct packed {
    logic [sidasc_pkg::CHAR_W-1:0] code;
    logic                          is_last;
  } text_char_t;

  // characters still owed by the block, oldest first
  text_char_t expected_chars[$];

  // decimal text of one signed value: optional minus, then digits from the top
  function automatic void queue_text(input logic [sidasc_pkg::VALUE_W-1:0] value);
    logic                           neg;
    logic [sidasc_pkg::VALUE_W-1:0] mag;
    logic [3:0]                     digit [sidasc_pkg::MAX_DIGITS];
    int                             count;
    int                             i;
    neg = value[sidasc_pkg::VALUE_W-1];
    // unsigned negate, so the most negative value keeps its full magnitude
    mag = neg ? ({sidasc_pkg::VALUE_W{1'b0}} - value) : value;
    count = 0;
    do begin
      digit[count] = 4'(mag % 32'd10);
      count++;
      mag = mag / 32'd10;
    end while (mag != 0 && count < sidasc_pkg::MAX_DIGITS);
    if (neg) begin
      expected_chars.push_back('{code: sidasc_pkg::CHAR_MINUS, is_last: 1'b0});
    end
    for (i = count - 1; i >= 0; i--) begin
      expected_chars.push_back('{code: sidasc_pkg::CHAR_ZERO + sidasc_pkg::CHAR_W'(digit[i]),
                                 is_last: (i == 0)});
    end
  endfunction

  // watch both channels on the same edge the block sees
  always @(posedge clk) begin
    int         errs;
    text_char_t want;
    errs = 0;
    if (rst) begin
      fail_count    <= 0;
      chars_pending <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        queue_text(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          $error("character: expected none, actual %0d", m_tdata[sidasc_pkg::CHAR_W-1:0]);
          errs++;
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata[sidasc_pkg::CHAR_W-1:0] !== want.code) begin
            $error("character: expected %0d, actual %0d", want.code,
                   m_tdata[sidasc_pkg::CHAR_W-1:0]);
            errs++;
          end
          if (m_tlast !== want.is_last) begin
            $error("last_char: expected %0d, actual %0d", want.is_last, m_tlast);
            errs++;
          end
        end
      end
      fail_count    <= fail_count + errs;
      chars_pending <= expected_chars.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the decimal text converter bench: clock, reset, stimulus and verdict
module testbench;

  localparam int RANDOM_ITEMS = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 32;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int mismatches;
  int chars_pending;
  int cycles = 0;
  bit steady = 1'b0;  // no idling on either side while set

  signed_int_to_decimal_ascii_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  decimal_text_monitor monitor (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fail_count    (mismatches),
    .chars_pending (chars_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // one value per transaction, with random gaps before it
  task automatic send_value(input logic [31:0] value);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    // tready is stable by the falling edge, so sample it there
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // value with a chosen number of digits and a random sign
  function automatic logic [31:0] value_of_length(input int digits, input bit neg);
    longint lo;
    longint hi;
    longint mag;
    lo = (digits == 1) ? 64'sd0 : longint'(10) ** (digits - 1);
    hi = longint'(10) ** digits - 1;
    if (hi > 64'sd2147483647) hi = neg ? 64'sd2147483648 : 64'sd2147483647;
    mag = lo + (longint'($urandom) % (hi - lo + 1));
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  initial begin
    logic [31:0] corner [$];
    int          kind;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, single digits, length boundaries, both extremes, bit patterns
    corner = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99, 32'd100,
               32'd999999999, 32'd1000000000, -32'sd999999999, -32'sd1000000000,
               32'd1000000001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
               32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, -32'sd1234567890};
    foreach (corner[i]) send_value(corner[i]);

    // random: mostly spread over text lengths, some raw bit patterns
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 150 && n < 210);
      kind = int'($urandom_range(0, 3));
      if (kind == 0) send_value($urandom);
      else send_value(value_of_length(int'($urandom_range(1, 10)),
                                      1'($urandom_range(0, 1))));
    end
    steady = 1'b0;

    s_tvalid <= 1'b0;
    do @(negedge clk); while (chars_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
